>>> rtl/core/dsra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsra_pkg
// Shared types and constants of the decayed spike RGB accumulator: channel
// payloads, command and channel codes, register indexes, divider request.
// ----------------------------------------------------------------------------
package dsra_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int PIXEL_BITS   = 3 * CHANNEL_BITS;
  localparam int TS_W         = 32;
  localparam int COORD_W      = 10;
  localparam int DIM_W        = 9;
  localparam int GRAN_W       = 16;
  localparam int RATE_W       = 17;
  localparam int WEIGHT_W     = 32;
  localparam int IDX_W        = 20;   // x + y * width before truncation
  localparam int PIX_IDX_W    = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CHANNEL_BITS-1:0] CH_MAX = {CHANNEL_BITS{1'b1}};

  // commands
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_RENDER = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // trigger channels
  localparam logic [3:0] TRIG_RED       = 4'd1;
  localparam logic [3:0] TRIG_GREEN     = 4'd2;
  localparam logic [3:0] TRIG_BLUE      = 4'd3;
  localparam logic [3:0] TRIG_RED_GREEN = 4'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_END_TIME_NOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_END_TIME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_GRANULARITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 3'd6;

  typedef struct packed {
    logic [1:0]         command;
    logic [TS_W-1:0]    timestamp;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [3:0]         trigger_channel;
  } req_t;

  typedef struct packed {
    logic [PIX_IDX_W-1:0]    pixel_index;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic                    applied;
    logic                    frame_stopped;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [TS_W-1:0]   dividend;
    logic [GRAN_W-1:0] divisor;
  } div_req_t;

endpackage

>>> rtl/core/dsra_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsra_stream_if
// Valid/ready channel carrying one payload of a chosen type per transaction.
// ----------------------------------------------------------------------------
interface dsra_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/dsra_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsra_div
// Iterative unsigned divider, 32 by 16 bits, two restoring steps per cycle.
// A quotient is ready when it is flagged by a one-cycle done.
// ----------------------------------------------------------------------------
module dsra_div (
  input  logic                      clk,
  input  logic                      rst,
  input  dsra_pkg::div_req_t        req,
  output logic                      done,
  output logic [dsra_pkg::TS_W-1:0] quotient
);
  import dsra_pkg::*;

  localparam int ITER   = TS_W / 2;
  localparam int CNT_W  = $clog2(ITER);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITER - 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [GRAN_W-1:0]    divisor;
  logic [GRAN_W-1:0]    rem;
  logic [TS_W-1:0]      quo;

  logic [GRAN_W:0]      trial1;
  logic [GRAN_W:0]      trial2;
  logic                 ge1;
  logic                 ge2;
  logic [GRAN_W-1:0]    rem1;
  logic [GRAN_W-1:0]    rem_next;

  // two dependent restoring steps
  always_comb begin
    trial1   = {rem, quo[TS_W-1]};
    ge1      = trial1 >= {1'b0, divisor};
    rem1     = ge1 ? GRAN_W'(trial1 - {1'b0, divisor}) : trial1[GRAN_W-1:0];
    trial2   = {rem1, quo[TS_W-2]};
    ge2      = trial2 >= {1'b0, divisor};
    rem_next = ge2 ? GRAN_W'(trial2 - {1'b0, divisor}) : trial2[GRAN_W-1:0];
  end

  // iteration control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        divisor <= req.divisor;
        rem     <= '0;
        quo     <= req.dividend;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[TS_W-3:0], ge1, ge2};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/core/decayed_spike_rgb_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decayed_spike_rgb_accumulator
// Renders time-decayed events into an RGB frame store, with clear and read.
// ----------------------------------------------------------------------------
// One transaction at a time. A render that decays waits on the divider,
// which retires two quotient bits per cycle and turns the age of the
// event into decay steps, and then goes to a multiply, an add, a weight
// check, and a read and write of the pixel in the frame memory. A render
// with zero granularity skips the divide and the multiply. A read, a render
// that is not before the end time, or a render on a stopped frame goes
// straight to the read of the pixel. A clear sweeps the frame memory one
// pixel per cycle and then loads its result. Reset runs the same sweep
// before the first request is accepted. A new request can be taken in the
// cycle after the result is loaded, and a result that is not yet taken
// holds the block.
// Configuration writes are taken at any time and must only be issued while
// the block is idle.
// ----------------------------------------------------------------------------
module decayed_spike_rgb_accumulator #(
  parameter int FRAME_PIXELS = 65536
) (
  input  logic          clk,
  input  logic          rst,
  dsra_stream_if.sink   req,
  dsra_stream_if.source rsp,
  dsra_stream_if.sink   cfg
);
  import dsra_pkg::*;

  localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam logic [AW-1:0]  ADDR_LAST  = AW'(FRAME_PIXELS - 1);
  localparam logic [IDX_W:0] PIXEL_LIM  = (IDX_W + 1)'(FRAME_PIXELS);
  localparam int PROD_W = TS_W + 1 + RATE_W;
  localparam int ROW_W  = DIM_W + COORD_W;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_DECODE, S_DIV, S_MUL, S_ADD, S_CHECK,
    S_MEM_RD, S_MEM_USE, S_FINISH
  } state_t;

  // configuration registers
  logic                       end_time_now;
  logic [TS_W-1:0]            fixed_end_time;
  logic signed [WEIGHT_W-1:0] initial_weight;
  logic [GRAN_W-1:0]          time_granularity;
  logic signed [RATE_W-1:0]   decay_rate;
  logic [DIM_W-1:0]           frame_width;
  logic [DIM_W-1:0]           frame_height;

  // sequencer and frame state
  state_t                     state;
  req_t                       item;
  logic [IDX_W-1:0]           idx;
  logic                       in_range;
  logic [TS_W-1:0]            end_time_reg;
  logic                       end_time_valid;
  logic                       stopped;
  logic                       clear_pending;
  logic [AW-1:0]              sweep_addr;
  logic                       modify;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   weight;
  logic [CHANNEL_BITS-1:0]    weight_clip;
  logic [PIXEL_BITS-1:0]      pix;
  logic                       applied;
  logic                       rsp_valid;
  rsp_t                       rsp_data;

  // frame memory
  logic [PIXEL_BITS-1:0]      frame_mem [FRAME_PIXELS];
  logic [PIXEL_BITS-1:0]      rd_data;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [PIXEL_BITS-1:0]      mem_wdata;

  // divider
  div_req_t                   div_req;
  logic                       div_done;
  logic [TS_W-1:0]            div_quo;

  // decode helpers
  logic [ROW_W-1:0]           row_base;
  logic [IDX_W-1:0]           idx_next;
  logic                       in_range_next;
  logic [TS_W-1:0]            end_sel;
  logic                       render_go;
  logic                       before_end;
  logic signed [TS_W:0]       quo_s;
  logic [CHANNEL_BITS-1:0]    cur_r, cur_g, cur_b;
  logic [CHANNEL_BITS-1:0]    new_r, new_g, new_b;

  function automatic logic [CHANNEL_BITS-1:0] sat_add(
    input logic [CHANNEL_BITS-1:0] c,
    input logic [CHANNEL_BITS-1:0] w
  );
    logic [CHANNEL_BITS:0] s;
    s = {1'b0, c} + {1'b0, w};
    return s[CHANNEL_BITS] ? CH_MAX : s[CHANNEL_BITS-1:0];
  endfunction

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_time_now     <= 1'b1;
      fixed_end_time   <= '0;
      initial_weight   <= WEIGHT_W'(255);
      time_granularity <= GRAN_W'(1);
      decay_rate       <= '1;
      frame_width      <= DIM_W'(256);
      frame_height     <= DIM_W'(256);
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_END_TIME_NOW:     end_time_now     <= cfg.data.value[0];
        REG_FIXED_END_TIME:   fixed_end_time   <= cfg.data.value[TS_W-1:0];
        REG_INITIAL_WEIGHT:   initial_weight   <= cfg.data.value[WEIGHT_W-1:0];
        REG_TIME_GRANULARITY: time_granularity <= cfg.data.value[GRAN_W-1:0];
        REG_DECAY_RATE:       decay_rate       <= cfg.data.value[RATE_W-1:0];
        REG_FRAME_WIDTH:      frame_width      <= cfg.data.value[DIM_W-1:0];
        REG_FRAME_HEIGHT:     frame_height     <= cfg.data.value[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // linear address and range check of the incoming request
  always_comb begin
    row_base      = ROW_W'(req.data.pixel_y) * ROW_W'(frame_width);
    idx_next      = IDX_W'(req.data.pixel_x) + IDX_W'(row_base);
    in_range_next = (req.data.pixel_x < COORD_W'(frame_width)) &&
                    (req.data.pixel_y < COORD_W'(frame_height)) &&
                    ({1'b0, idx_next} < PIXEL_LIM);
  end

  // end time and render decision
  always_comb begin
    if (!end_time_now) begin
      end_sel = fixed_end_time;
    end else if (end_time_valid) begin
      end_sel = end_time_reg;
    end else begin
      end_sel = item.timestamp;
    end
    render_go  = (item.command == CMD_RENDER) && !stopped;
    before_end = item.timestamp < end_sel;
  end

  // divider request
  always_comb begin
    div_req.start    = (state == S_DECODE) && render_go && before_end &&
                       (time_granularity != '0);
    div_req.dividend = end_sel - item.timestamp;
    div_req.divisor  = time_granularity;
  end

  dsra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign quo_s = {1'b0, div_quo};

  // saturating channel update
  always_comb begin
    cur_r = rd_data[PIXEL_BITS-1 -: CHANNEL_BITS];
    cur_g = rd_data[2*CHANNEL_BITS-1 -: CHANNEL_BITS];
    cur_b = rd_data[CHANNEL_BITS-1:0];
    new_r = cur_r;
    new_g = cur_g;
    new_b = cur_b;
    if (item.trigger_channel inside {TRIG_RED, TRIG_RED_GREEN}) begin
      new_r = sat_add(cur_r, weight_clip);
    end
    if (item.trigger_channel inside {TRIG_GREEN, TRIG_RED_GREEN}) begin
      new_g = sat_add(cur_g, weight_clip);
    end
    if (item.trigger_channel == TRIG_BLUE) begin
      new_b = sat_add(cur_b, weight_clip);
    end
  end

  // memory write port: sweep or pixel update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = {new_r, new_g, new_b};
    if (state == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = '0;
    end else if (state == S_MEM_USE && modify) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= frame_mem[idx[AW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_SWEEP;
      sweep_addr     <= '0;
      clear_pending  <= 1'b0;
      end_time_reg   <= '0;
      end_time_valid <= 1'b0;
      stopped        <= 1'b0;
      modify         <= 1'b0;
      applied        <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      // response taken; a finishing item reloads it below
      if (rsp_valid && rsp.ready && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          if (sweep_addr == ADDR_LAST) begin
            sweep_addr    <= '0;
            clear_pending <= 1'b0;
            state         <= clear_pending ? S_FINISH : S_IDLE;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            item     <= req.data;
            idx      <= idx_next;
            in_range <= in_range_next;
            state    <= S_DECODE;
          end
        end
        S_DECODE: begin
          modify  <= 1'b0;
          applied <= 1'b0;
          pix     <= '0;
          if (item.command == CMD_CLEAR) begin
            end_time_valid <= 1'b0;
            end_time_reg   <= '0;
            stopped        <= 1'b0;
            clear_pending  <= 1'b1;
            state          <= S_SWEEP;
          end else if (render_go) begin
            if (end_time_now && !end_time_valid) begin
              end_time_reg   <= item.timestamp;
              end_time_valid <= 1'b1;
            end
            if (!before_end) begin
              state <= S_MEM_RD;
            end else if (time_granularity == '0) begin
              prod  <= '0;
              state <= S_ADD;
            end else begin
              state <= S_DIV;
            end
          end else begin
            state <= S_MEM_RD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(quo_s) * PROD_W'(decay_rate);
          state <= S_ADD;
        end
        S_ADD: begin
          weight <= prod + PROD_W'(initial_weight);
          state  <= S_CHECK;
        end
        S_CHECK: begin
          weight_clip <= (weight[PROD_W-2:CHANNEL_BITS] == '0) ?
                         weight[CHANNEL_BITS-1:0] : CH_MAX;
          if (weight[PROD_W-1]) begin
            stopped <= 1'b1;
          end else if (in_range && item.trigger_channel inside
                       {TRIG_RED, TRIG_GREEN, TRIG_BLUE, TRIG_RED_GREEN}) begin
            modify <= 1'b1;
          end
          state <= S_MEM_RD;
        end
        S_MEM_RD: begin
          state <= S_MEM_USE;
        end
        S_MEM_USE: begin
          if (modify) begin
            pix     <= {new_r, new_g, new_b};
            applied <= 1'b1;
          end else begin
            pix <= in_range ? rd_data : '0;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid              <= 1'b1;
            rsp_data.pixel_index   <= idx[PIX_IDX_W-1:0];
            rsp_data.red           <= pix[PIXEL_BITS-1 -: CHANNEL_BITS];
            rsp_data.green         <= pix[2*CHANNEL_BITS-1 -: CHANNEL_BITS];
            rsp_data.blue          <= pix[CHANNEL_BITS-1:0];
            rsp_data.applied       <= applied;
            rsp_data.frame_stopped <= stopped;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // a pixel that was updated cannot belong to a stopped frame
  a_applied_not_stopped: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.data.applied && rsp.data.frame_stopped))
    else $error("applied result reported on a stopped frame");

  // the divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside of divide wait");

  // pixel updates only hit in-range addresses
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != S_SWEEP) |-> (in_range && modify))
    else $error("frame write to an out-of-range pixel");

  // no request is taken while the store is being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> !req.ready)
    else $error("request accepted during frame sweep");

endmodule

>>> sim/decayed_spike_rgb_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decayed_spike_rgb_accumulator_tb
// Drives clear, render and read requests through the request channel under
// several register settings and random idling on both sides. A scoreboard
// keeps its own copy of the frame store and predicts every response.
// ----------------------------------------------------------------------------
module decayed_spike_rgb_accumulator_tb;
  import dsra_pkg::*;

  localparam int CLK_HALF_NS  = 6;
  localparam int FRAME_PIXELS = 65536;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 700;
  localparam logic [1:0] CMD_SPARE = 2'd3;   // decoded like a read

  // scoreboard: frame store copy and queue of predicted pixel responses
  class frame_scoreboard;
    logic        end_now;
    logic [31:0] fixed_end;
    logic [31:0] init_weight;
    logic [15:0] gran;
    logic [16:0] rate;
    logic [8:0]  width;
    logic [8:0]  height;
    logic [31:0] end_latch;
    bit          end_latched;
    bit          stopped;
    logic [23:0] pixels [int unsigned];
    rsp_t        expected_pixels [$];
    int          n_errors;

    function new();
      end_now     = 1'b1;
      fixed_end   = '0;
      init_weight = 32'd255;
      gran        = 16'd1;
      rate        = '1;
      width       = 9'd256;
      height      = 9'd256;
      end_latch   = '0;
      end_latched = 0;
      stopped     = 0;
      n_errors    = 0;
    endfunction

    function void write_reg(cfg_t c);
      case (c.index)
        REG_END_TIME_NOW:     end_now     = c.value[0];
        REG_FIXED_END_TIME:   fixed_end   = c.value;
        REG_INITIAL_WEIGHT:   init_weight = c.value;
        REG_TIME_GRANULARITY: gran        = c.value[15:0];
        REG_DECAY_RATE:       rate        = c.value[16:0];
        REG_FRAME_WIDTH:      width       = c.value[8:0];
        REG_FRAME_HEIGHT:     height      = c.value[8:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] sat_add(logic [7:0] c, longint wt);
      longint s;
      s = longint'(c) + wt;
      return (s > longint'(CH_MAX)) ? CH_MAX : s[7:0];
    endfunction

    // one accepted request -> one predicted response
    function void note_request(req_t r);
      int unsigned x, y, idx, end_t, age;
      longint      wt;
      bit          in_range, hit;
      logic [7:0]  red, grn, blu;
      logic [23:0] pix;
      rsp_t        e;
      x        = r.pixel_x;
      y        = r.pixel_y;
      idx      = x + y * width;
      in_range = x < width && y < height && idx < FRAME_PIXELS;
      hit      = 0;
      if (r.command == CMD_CLEAR) begin
        pixels.delete();
        end_latch   = '0;
        end_latched = 0;
        stopped     = 0;
      end else if (r.command == CMD_RENDER && !stopped) begin
        if (end_now) begin
          if (!end_latched) begin
            end_latch   = r.timestamp;
            end_latched = 1;
          end
          end_t = end_latch;
        end else begin
          end_t = fixed_end;
        end
        if (r.timestamp < end_t) begin
          wt = longint'($signed(init_weight));
          if (gran != 0) begin
            age = end_t - r.timestamp;
            wt += longint'(age / gran) * longint'($signed(rate));
          end
          if (wt < 0) begin
            stopped = 1;
          end else if (in_range && (r.trigger_channel == TRIG_RED ||
                     r.trigger_channel == TRIG_GREEN || r.trigger_channel == TRIG_BLUE ||
                     r.trigger_channel == TRIG_RED_GREEN)) begin
            pix = pixels.exists(idx) ? pixels[idx] : '0;
            {red, grn, blu} = pix;
            if (r.trigger_channel == TRIG_RED || r.trigger_channel == TRIG_RED_GREEN)
              red = sat_add(red, wt);
            if (r.trigger_channel == TRIG_GREEN || r.trigger_channel == TRIG_RED_GREEN)
              grn = sat_add(grn, wt);
            if (r.trigger_channel == TRIG_BLUE)
              blu = sat_add(blu, wt);
            pixels[idx] = {red, grn, blu};
            hit = 1;
          end
        end
      end
      pix = '0;
      if (in_range && r.command != CMD_CLEAR && pixels.exists(idx))
        pix = pixels[idx];
      e.pixel_index   = idx[15:0];
      e.red           = pix[23:16];
      e.green         = pix[15:8];
      e.blue          = pix[7:0];
      e.applied       = hit;
      e.frame_stopped = stopped;
      expected_pixels.push_back(e);
    endfunction

    // compare one accepted response with the oldest prediction
    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_pixels.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected response at pixel_index %0d", got.pixel_index);
        return;
      end
      e = expected_pixels.pop_front();
      if (got.pixel_index !== e.pixel_index || got.red !== e.red ||
          got.green !== e.green || got.blue !== e.blue ||
          got.applied !== e.applied || got.frame_stopped !== e.frame_stopped) begin
        n_errors++;
        if (n_errors <= 10)
          $display({"response error: exp idx %0d rgb %0d/%0d/%0d app %0d stop %0d,",
                    " got idx %0d rgb %0d/%0d/%0d app %0d stop %0d"},
                   e.pixel_index, e.red, e.green, e.blue, e.applied, e.frame_stopped,
                   got.pixel_index, got.red, got.green, got.blue, got.applied,
                   got.frame_stopped);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  dsra_stream_if #(.payload_t(req_t)) req_if ();
  dsra_stream_if #(.payload_t(rsp_t)) rsp_if ();
  dsra_stream_if #(.payload_t(cfg_t)) cfg_if ();

  decayed_spike_rgb_accumulator #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  frame_scoreboard sb = new();

  int n_accepted   = 0;
  int src_idle_pct = 20;
  int snk_idle_pct = 46;

  // stimulus shaping for the current register setting
  int unsigned gen_w, gen_h, gen_base, gen_safe, gen_stop;
  bit          gen_latch_pending;

  always #(CLK_HALF_NS) clk = ~clk;

  // run limit
  initial begin
    #(64'd2 * CLK_HALF_NS * LIMIT_CYCLES);
    $display("Mismatches found");
    $finish;
  end

  // transaction monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready)
        sb.write_reg(cfg_if.data);
      if (req_if.valid && req_if.ready) begin
        sb.note_request(req_if.data);
        n_accepted++;
        if (n_accepted == 320) begin
          src_idle_pct = 46;
          snk_idle_pct = 20;
        end else if (n_accepted == 640) begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      end
      if (rsp_if.valid && rsp_if.ready)
        sb.check_response(rsp_if.data);
    end
  end

  // response ready with random stalls and one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic req_t make_req(logic [1:0] cmd, logic [31:0] ts, int unsigned x,
                                    int unsigned y, logic [3:0] ch);
    req_t r;
    r.command         = cmd;
    r.timestamp       = ts;
    r.pixel_x         = x[9:0];
    r.pixel_y         = y[9:0];
    r.trigger_channel = ch;
    return r;
  endfunction

  task automatic send_item(input req_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.value <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  // stop offering and let every pending response come back
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // wait for idle, write all registers, work out which event ages keep the weight non-negative, optionally clear
  task automatic setup_phase(input bit now, input logic [31:0] fixed, input int init,
                             input int unsigned gran, input int rate, input int unsigned w,
                             input int unsigned h, input bit do_clear);
    longint iw, rt, steps, s, st;
    wait_idle();
    write_reg(REG_END_TIME_NOW, {31'd0, now});
    write_reg(REG_FIXED_END_TIME, fixed);
    write_reg(REG_INITIAL_WEIGHT, init);
    write_reg(REG_TIME_GRANULARITY, gran);
    write_reg(REG_DECAY_RATE, rate);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_if.valid <= 1'b0;
    iw = init;
    rt = rate;
    if (iw < 0) begin
      gen_safe = 1000;
      gen_stop = 1;
    end else if (gran == 0 || rt >= 0) begin
      gen_safe = 32'hFFFF_FFFF;
      gen_stop = 0;
    end else begin
      steps    = iw / (-rt);
      s        = steps * gran + gran - 1;
      st       = (steps + 1) * gran;
      gen_safe = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
      gen_stop = (st > 64'hFFFF_FFFF) ? 0 : st[31:0];
    end
    gen_w             = w;
    gen_h             = h;
    gen_base          = now ? $urandom_range(32'hFFFF_FFFF, gen_stop) : fixed;
    gen_latch_pending = now;
    if (do_clear)
      send_item(make_req(CMD_CLEAR, $urandom, $urandom_range(1023), $urandom_range(1023),
                         $urandom_range(15)));
  endtask

  // random renders and reads, closed by an event just inside and just past
  // the age at which the weight turns negative
  task automatic random_batch(input int count);
    int unsigned ts, x, y;
    int          p;
    logic [3:0]  ch;
    logic [1:0]  cmd;
    for (int i = 0; i < count + 5; i++) begin
      if ($urandom_range(99) < 80) begin
        x = $urandom_range(gen_w - 1);
        y = $urandom_range(gen_h - 1);
      end else begin
        x = $urandom_range(1023);
        y = $urandom_range(1023);
      end
      ch  = ($urandom_range(99) < 85) ? $urandom_range(4, 1) : $urandom_range(15);
      cmd = CMD_RENDER;
      p   = $urandom_range(99);
      if (gen_latch_pending) begin
        ts                = gen_base;
        gen_latch_pending = 0;
      end else if (i == count) begin
        ts = gen_base - gen_safe;
      end else if (i == count + 1 && gen_stop != 0) begin
        ts = gen_base - gen_stop;
      end else if (i >= count) begin
        cmd = (i == count + 2) ? CMD_RENDER : CMD_READ;
        ts  = gen_base - $urandom_range(gen_safe / 16);
      end else if (p < 38) begin
        cmd = ($urandom_range(9) == 0) ? CMD_SPARE : CMD_READ;
        ts  = $urandom;
      end else if (p < 42) begin
        ts = gen_base + $urandom_range(1000);
      end else if (p < 70) begin
        ts = gen_base - $urandom_range(gen_safe);
      end else begin
        ts = gen_base - $urandom_range(gen_safe / 16);
      end
      send_item(make_req(cmd, ts, x, y, ch));
    end
  endtask

  // main sequence
  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part under the reset settings, end time taken from the first render
    send_item(make_req(CMD_READ, 0, 0, 0, 0));
    send_item(make_req(CMD_RENDER, 1000, 5, 3, TRIG_RED));       // latches end time
    send_item(make_req(CMD_RENDER, 999, 5, 3, TRIG_RED));
    send_item(make_req(CMD_RENDER, 990, 5, 3, TRIG_RED));        // red saturates
    send_item(make_req(CMD_RENDER, 995, 5, 3, TRIG_GREEN));
    send_item(make_req(CMD_RENDER, 1000, 5, 3, TRIG_BLUE));      // at end time
    send_item(make_req(CMD_RENDER, 32'hFFFF_FFFF, 5, 3, TRIG_BLUE));
    send_item(make_req(CMD_RENDER, 998, 5, 3, TRIG_BLUE));
    send_item(make_req(CMD_RENDER, 900, 255, 255, TRIG_RED_GREEN));
    send_item(make_req(CMD_RENDER, 999, 256, 0, TRIG_RED));       // column past edge
    send_item(make_req(CMD_RENDER, 999, 1023, 1023, TRIG_RED_GREEN));
    send_item(make_req(CMD_RENDER, 999, 7, 7, 4'd0));
    send_item(make_req(CMD_RENDER, 999, 7, 7, 4'd15));
    send_item(make_req(CMD_RENDER, 999, 7, 7, 4'd5));
    send_item(make_req(CMD_READ, 0, 5, 3, 0));
    send_item(make_req(CMD_SPARE, 0, 255, 255, 0));
    send_item(make_req(CMD_READ, 0, 1023, 1023, 0));
    send_item(make_req(CMD_RENDER, 0, 1, 1, TRIG_RED));          // negative weight
    send_item(make_req(CMD_RENDER, 999, 1, 1, TRIG_RED));        // frame stopped
    send_item(make_req(CMD_READ, 0, 5, 3, 0));
    send_item(make_req(CMD_CLEAR, 0, 5, 3, 0));
    send_item(make_req(CMD_READ, 0, 5, 3, 0));
    send_item(make_req(CMD_RENDER, 0, 0, 0, TRIG_GREEN));        // latches zero

    // fixed end at the top, no decay, small frame
    setup_phase(0, 32'hFFFF_FFFF, 20, 0, -65536, 16, 8, 0);
    random_batch(150);
    // end-now, slowest decay, one-pixel-wide frame; latch from the clear above
    setup_phase(1, 0, 200, 65535, -1, 1, 256, 1);
    random_batch(150);
    // fixed end of zero: nothing is ever older than the end
    setup_phase(0, 0, -2147483647 - 1, 1, 0, 256, 1, 1);
    random_batch(15);
    // growing weight from the largest start value
    setup_phase(0, 32'h8000_0000, 2147483647, 1, 65535, 256, 1, 0);
    random_batch(100);
    // most negative start value: an older event stops the frame unless its age is very large
    setup_phase(0, $urandom, -2147483647 - 1, 7, 5, 40, 40, 0);
    random_batch(20);
    setup_phase(1, 0, 100, 4, -3, 37, 23, 1);
    random_batch(250);
    repeat (2) begin
      setup_phase($urandom_range(1), $urandom, $urandom_range(1000), $urandom_range(300, 1),
                  -$urandom_range(20, 1), $urandom_range(256, 1), $urandom_range(256, 1), 1);
      random_batch(130);
    end

    wait_idle();
    if (sb.n_errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
